[design/orthic_triangle_feet_top_macros.svh]
// ---------------------------------------------------------------------------
// Orthic triangle feet: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ORTHIC_TRIANGLE_FEET_TOP_MACROS_SVH
`define ORTHIC_TRIANGLE_FEET_TOP_MACROS_SVH

// same-cycle implication
`define OTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/otf_pkg.sv]
// ---------------------------------------------------------------------------
// Orthic triangle feet: package
// Types and constants shared by the top level and the coordinate unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package otf_pkg;

  localparam int unsigned FEET   = 3;
  localparam int unsigned COORDS = 2 * FEET;

  // status that travels alongside each coordinate lane
  typedef struct packed {
    logic valid;
    logic zero;   // base side of zero length
    logic clip;   // coordinate saturated
  } otf_flag_t;

endpackage

[design/otf_if.sv]
// ---------------------------------------------------------------------------
// Orthic triangle feet: channel interfaces
// Triangle request channel and feet result channel, valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface otf_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;

  modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
  modport sink   (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

interface otf_out_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] foot_b_x;
  logic signed [COORD_BITS-1:0] foot_b_y;
  logic signed [COORD_BITS-1:0] foot_c_x;
  logic signed [COORD_BITS-1:0] foot_c_y;
  logic signed [COORD_BITS-1:0] foot_a_x;
  logic signed [COORD_BITS-1:0] foot_a_y;
  logic                         degenerate;
  logic                         clipped;

  modport source (output valid, foot_b_x, foot_b_y, foot_c_x, foot_c_y,
                  foot_a_x, foot_a_y, degenerate, clipped, input ready);
  modport sink   (input valid, foot_b_x, foot_b_y, foot_c_x, foot_c_y,
                  foot_a_x, foot_a_y, degenerate, clipped, output ready);
endinterface

[design/otf_coord.sv]
// ---------------------------------------------------------------------------
// Orthic triangle feet: coordinate unit
// round(p + num*dk/den), halves away from zero, saturated; pipelined
// multiply, one quotient bit per stage, then round and clamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module otf_coord
  import otf_pkg::*;
#(
  parameter int N = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [N-1:0]    p,
  input  logic signed [2*N+2:0]  num,
  input  logic signed [N:0]      dk,
  input  logic        [2*N+1:0]  den,
  output logic signed [N-1:0]    value,
  output otf_flag_t              flag
);

  localparam int A_W   = 2 * N + 2;   // |num|
  localparam int AD_W  = N + 1;       // |dk|
  localparam int H     = N + 1;       // split point of |num|
  localparam int PP_W  = H + AD_W;
  localparam int P_W   = A_W + AD_W;  // full product
  localparam int Q_W   = N + 2;       // quotient bits
  localparam int DEN_W = 2 * N + 2;
  localparam int N_W   = N + 4;       // sum before clamp

  localparam logic signed [N_W-1:0] LIM_HI = N_W'((64'sd1 <<< (N - 1)) - 64'sd1);
  localparam logic signed [N_W-1:0] LIM_LO = -N_W'(64'sd1 <<< (N - 1));

  // ---- C1: magnitudes and sign
  logic               v1, neg1, zero1;
  logic [A_W-1:0]     an1;
  logic [AD_W-1:0]    ad1;
  logic [DEN_W-1:0]   den1;
  logic signed [N-1:0] p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= num[2*N+2] ^ dk[N];
      an1   <= num[2*N+2] ? A_W'(-num) : A_W'(num);
      ad1   <= dk[N] ? AD_W'(-dk) : AD_W'(dk);
      zero1 <= (den == '0);
      den1  <= den;
      p1    <= p;
    end
  end

  // ---- C2: two partial products
  logic               v2, neg2, zero2;
  logic [PP_W-1:0]    pp_lo2, pp_hi2;
  logic [DEN_W-1:0]   den2;
  logic signed [N-1:0] p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo2 <= an1[H-1:0] * ad1;
      pp_hi2 <= an1[A_W-1:H] * ad1;
      neg2   <= neg1;
      zero2  <= zero1;
      den2   <= den1;
      p2     <= p1;
    end
  end

  // ---- divider: stage 0 loaded from the summed product
  logic [P_W-1:0] prod;
  assign prod = {pp_hi2, {H{1'b0}}} + P_W'(pp_lo2);

  logic               v_s    [0:Q_W];
  logic [DEN_W-1:0]   r_s    [0:Q_W];
  logic [Q_W-1:0]     w_s    [0:Q_W];   // dividend low bits, then quotient
  logic [DEN_W-1:0]   den_s  [0:Q_W];
  logic               neg_s  [0:Q_W];
  logic               zero_s [0:Q_W];
  logic signed [N-1:0] p_s   [0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_s[0]    <= {1'b0, prod[P_W-1:Q_W]};
      w_s[0]    <= prod[Q_W-1:0];
      den_s[0]  <= den2;
      neg_s[0]  <= neg2;
      zero_s[0] <= zero2;
      p_s[0]    <= p2;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [DEN_W:0] t, diff;
    logic           ge;

    assign t    = {r_s[j], w_s[j][Q_W-1]};
    assign diff = t - {1'b0, den_s[j]};
    assign ge   = (t >= {1'b0, den_s[j]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else if (en) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[j+1]    <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        w_s[j+1]    <= {w_s[j][Q_W-2:0], ge};
        den_s[j+1]  <= den_s[j];
        neg_s[j+1]  <= neg_s[j];
        zero_s[j+1] <= zero_s[j];
        p_s[j+1]    <= p_s[j];
      end
    end
  end

  // ---- F1: floor of signed quotient, add base
  logic                   vf1, zerof1;
  logic signed [N_W-1:0]  nf1;
  logic [DEN_W-1:0]       rff1, denf1;
  logic signed [N_W-1:0]  q_ext, qf;
  logic [DEN_W-1:0]       r_fin, rf;

  assign q_ext = $signed({{(N_W-Q_W){1'b0}}, w_s[Q_W]});
  assign r_fin = r_s[Q_W];

  always_comb begin
    if (!neg_s[Q_W]) begin
      qf = q_ext;
      rf = r_fin;
    end else if (r_fin == '0) begin
      qf = -q_ext;
      rf = '0;
    end else begin
      qf = -q_ext - N_W'(1);
      rf = den_s[Q_W] - r_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf1 <= 1'b0;
    end else if (en) begin
      vf1 <= v_s[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nf1    <= N_W'(p_s[Q_W]) + qf;
      rff1   <= rf;
      denf1  <= den_s[Q_W];
      zerof1 <= zero_s[Q_W];
    end
  end

  // ---- F2: round and clamp; this is the result register
  logic                  up;
  logic signed [N_W-1:0] nr;
  logic [DEN_W:0]        twice;

  assign twice = {rff1, 1'b0};

  always_comb begin
    up = 1'b0;
    if (rff1 != '0) begin
      if (!nf1[N_W-1]) begin
        up = (twice >= {1'b0, denf1});
      end else begin
        up = (twice > {1'b0, denf1});
      end
    end
    nr = nf1 + N_W'(up);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag.valid <= 1'b0;
    end else if (en) begin
      flag.valid <= vf1;
    end
    if (en) begin
      flag.zero <= zerof1;
      priority if (zerof1) begin
        value     <= '0;
        flag.clip <= 1'b0;
      end else if (nr > LIM_HI) begin
        value     <= LIM_HI[N-1:0];
        flag.clip <= 1'b1;
      end else if (nr < LIM_LO) begin
        value     <= LIM_LO[N-1:0];
        flag.clip <= 1'b1;
      end else begin
        value     <= nr[N-1:0];
        flag.clip <= 1'b0;
      end
    end
  end

endmodule

[design/orthic_triangle_feet_top.sv]
// ---------------------------------------------------------------------------
// Orthic triangle feet: top level
// Feet of the three altitudes of an integer triangle, exact rational
// projection, rounded half away from zero and saturated.
// ---------------------------------------------------------------------------
//  channel   | dir | handshake   | payload
//  ----------+-----+-------------+----------------------------------------
//  tri_in    | in  | valid/ready | ax ay bx by cx cy (COORD_BITS, signed)
//  feet_out  | out | valid/ready | foot_b/c/a x,y, degenerate, clipped
//
//  One request per cycle while results are taken; the pipeline holds a
//  restoring divider that retires one quotient bit per stage.
//  Reset (rst, synchronous) clears only the stage valid bits.
//  A result not taken freezes every stage; tri_in.ready drops in that
//  cycle, so nothing is lost or repeated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "orthic_triangle_feet_top_macros.svh"

module orthic_triangle_feet_top
  import otf_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  otf_in_if.sink    tri_in,
  otf_out_if.source feet_out
);

  localparam int N     = COORD_BITS;
  localparam int D_W   = N + 1;       // vertex difference
  localparam int M_W   = 2 * N + 2;   // product of differences
  localparam int NUM_W = 2 * N + 3;
  localparam int DEN_W = 2 * N + 2;

  localparam logic signed [N-1:0] MAX_C = N'((64'sd1 <<< (N - 1)) - 64'sd1);
  localparam logic signed [N-1:0] MIN_C = -N'(64'sd1 <<< (N - 1));

  // whole pipeline moves together
  logic en;
  assign en           = !feet_out.valid || feet_out.ready;
  assign tri_in.ready = en;

  // foot k projects R onto line P-Q; k = 0: B on C-A, 1: C on A-B, 2: A on B-C
  logic signed [N-1:0] px [FEET], py [FEET], qx [FEET], qy [FEET];
  logic signed [N-1:0] rx [FEET], ry [FEET];

  always_comb begin
    px[0] = tri_in.cx; py[0] = tri_in.cy;
    qx[0] = tri_in.ax; qy[0] = tri_in.ay;
    rx[0] = tri_in.bx; ry[0] = tri_in.by;
    px[1] = tri_in.ax; py[1] = tri_in.ay;
    qx[1] = tri_in.bx; qy[1] = tri_in.by;
    rx[1] = tri_in.cx; ry[1] = tri_in.cy;
    px[2] = tri_in.bx; py[2] = tri_in.by;
    qx[2] = tri_in.cx; qy[2] = tri_in.cy;
    rx[2] = tri_in.ax; ry[2] = tri_in.ay;
  end

  // ---- S1: differences
  logic v1, v2, v3;
  logic signed [D_W-1:0] dx1 [FEET], dy1 [FEET], vx1 [FEET], vy1 [FEET];
  logic signed [N-1:0]   px1 [FEET], py1 [FEET];

  // ---- S2: products
  logic signed [M_W-1:0] mdx2 [FEET], mdy2 [FEET], mvx2 [FEET], mvy2 [FEET];
  logic signed [D_W-1:0] dx2 [FEET], dy2 [FEET];
  logic signed [N-1:0]   px2 [FEET], py2 [FEET];

  // ---- S3: dot product and squared length
  logic signed [NUM_W-1:0] num3 [FEET];
  logic [DEN_W-1:0]        den3 [FEET];
  logic signed [D_W-1:0]   dx3 [FEET], dy3 [FEET];
  logic signed [N-1:0]     px3 [FEET], py3 [FEET];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= tri_in.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  for (genvar k = 0; k < FEET; k++) begin : g_front
    always_ff @(posedge clk) begin
      if (en) begin
        dx1[k]  <= D_W'(qx[k]) - D_W'(px[k]);
        dy1[k]  <= D_W'(qy[k]) - D_W'(py[k]);
        vx1[k]  <= D_W'(rx[k]) - D_W'(px[k]);
        vy1[k]  <= D_W'(ry[k]) - D_W'(py[k]);
        px1[k]  <= px[k];
        py1[k]  <= py[k];

        mdx2[k] <= dx1[k] * dx1[k];
        mdy2[k] <= dy1[k] * dy1[k];
        mvx2[k] <= vx1[k] * dx1[k];
        mvy2[k] <= vy1[k] * dy1[k];
        dx2[k]  <= dx1[k];
        dy2[k]  <= dy1[k];
        px2[k]  <= px1[k];
        py2[k]  <= py1[k];

        den3[k] <= DEN_W'($unsigned(mdx2[k] + mdy2[k]));
        num3[k] <= NUM_W'(mvx2[k]) + NUM_W'(mvy2[k]);
        dx3[k]  <= dx2[k];
        dy3[k]  <= dy2[k];
        px3[k]  <= px2[k];
        py3[k]  <= py2[k];
      end
    end
  end

  // ---- coordinate lanes: 2k is x of foot k, 2k+1 is y
  logic signed [N-1:0] lane_val  [COORDS];
  otf_flag_t           lane_flag [COORDS];

  for (genvar k = 0; k < FEET; k++) begin : g_lane
    otf_coord #(.N(N)) u_x (
      .clk, .rst, .en,
      .in_valid (v3),
      .p        (px3[k]),
      .num      (num3[k]),
      .dk       (dx3[k]),
      .den      (den3[k]),
      .value    (lane_val[2*k]),
      .flag     (lane_flag[2*k])
    );
    otf_coord #(.N(N)) u_y (
      .clk, .rst, .en,
      .in_valid (v3),
      .p        (py3[k]),
      .num      (num3[k]),
      .dk       (dy3[k]),
      .den      (den3[k]),
      .value    (lane_val[2*k+1]),
      .flag     (lane_flag[2*k+1])
    );
  end

  logic [COORDS-1:0] lane_valid, lane_zero, lane_clip;
  always_comb begin
    for (int i = 0; i < COORDS; i++) begin
      lane_valid[i] = lane_flag[i].valid;
      lane_zero[i]  = lane_flag[i].zero;
      lane_clip[i]  = lane_flag[i].clip;
    end
  end

  assign feet_out.valid      = lane_valid[0];
  assign feet_out.foot_b_x   = lane_val[0];
  assign feet_out.foot_b_y   = lane_val[1];
  assign feet_out.foot_c_x   = lane_val[2];
  assign feet_out.foot_c_y   = lane_val[3];
  assign feet_out.foot_a_x   = lane_val[4];
  assign feet_out.foot_a_y   = lane_val[5];
  assign feet_out.degenerate = |lane_zero;
  assign feet_out.clipped    = |lane_clip;

  // some coordinate sits at a rail
  logic [COORDS-1:0] at_rail;
  always_comb begin
    for (int i = 0; i < COORDS; i++) begin
      at_rail[i] = (lane_val[i] == MAX_C) || (lane_val[i] == MIN_C);
    end
  end

  // a zero-length side always forces its foot to the origin
  logic zero_foot;
  assign zero_foot = (lane_val[0] == '0 && lane_val[1] == '0) ||
                     (lane_val[2] == '0 && lane_val[3] == '0) ||
                     (lane_val[4] == '0 && lane_val[5] == '0);

  `OTF_ASSERT_NOW(a_lanes_aligned, 1'b1, (lane_valid == '0) || (lane_valid == '1), "lanes out of step")
  `OTF_ASSERT_NOW(a_degen_origin, feet_out.valid && feet_out.degenerate, zero_foot, "degenerate foot not at origin")
  `OTF_ASSERT_NOW(a_clip_rail, feet_out.valid && feet_out.clipped, at_rail != '0, "clipped with no coordinate at a rail")
  `OTF_ASSERT_NEXT(a_stall_holds, v1 && !en, v1, "first stage lost a request while stalled")

endmodule
